[src/ded_pkg.sv]
// Shared types and constants for the descriptor Euclidean distance block.
`default_nettype none

package ded_pkg;

  localparam int ELEM_W     = 16;
  localparam int DIFF_W     = ELEM_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = 42;
  localparam int ROOT_W     = 21;
  localparam int ROOT_ITERS = ROOT_W;
  localparam int CNT_W      = $clog2(ROOT_ITERS);

  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0]  ROOT_BIT0 = SUM_W'(1) << (2 * (ROOT_W - 1));
  localparam logic [ROOT_W:0]   ROOT_LIM  = (ROOT_W + 1)'(1) << ROOT_W;
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(ROOT_ITERS - 1);

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     is_last;
  } ded_in_t;

  typedef struct packed {
    logic [ROOT_W-1:0] distance;
    logic [SUM_W-1:0]  sum_squares;
  } ded_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_ROOT,
    ST_EMIT
  } ded_state_t;

  typedef struct packed {
    logic load_sq;
    logic acc_upd;
    logic root_start;
    logic root_step;
    logic out_load;
  } ded_cmd_t;

  typedef struct packed {
    logic last_r;
    logic root_last;
  } ded_sts_t;

endpackage

`default_nettype wire

[src/ded_ctrl.sv]
// Controller state machine: sequences square, accumulate, root and emit.
`default_nettype none

module ded_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ded_pkg::ded_sts_t sts,
  output ded_pkg::ded_cmd_t      cmd
);
  import ded_pkg::*;

  ded_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_sq = 1'b1;
          state_nxt   = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_upd    = 1'b1;
        cmd.root_start = sts.last_r;
        state_nxt      = sts.last_r ? ST_ROOT : ST_IDLE;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[src/ded_dpath.sv]
// Datapath: squared difference, saturating accumulator, bit-serial root, output register.
`default_nettype none

module ded_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ded_pkg::ded_in_t  in_data,
  input  wire ded_pkg::ded_cmd_t cmd,
  output ded_pkg::ded_sts_t      sts,
  output ded_pkg::ded_out_t      out_data
);
  import ded_pkg::*;

  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sq_nxt;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W:0]    trial;
  logic              fits;

  logic [SUM_W-1:0]  sq_r;
  logic              last_r;
  logic [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  rem_r;
  logic [SUM_W-1:0]  res_r;
  logic [SUM_W-1:0]  bit_r;
  logic [CNT_W-1:0]  cnt_r;
  ded_out_t          out_r;

  // Exact difference, its magnitude and the square, saturated to the sum range.
  always_comb begin
    diff   = {in_data.elem_a[ELEM_W-1], in_data.elem_a}
           - {in_data.elem_b[ELEM_W-1], in_data.elem_b};
    mag    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    prod   = PROD_W'(mag) * PROD_W'(mag);
    sq_nxt = ((ROOT_W + 1)'(mag) >= ROOT_LIM) ? SUM_MAX : SUM_W'(prod);
  end

  assign sum_wide = {1'b0, acc_r} + {1'b0, sq_r};
  assign sum_nxt  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign trial    = {1'b0, res_r} + {1'b0, bit_r};
  assign fits     = {1'b0, rem_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      last_r <= 1'b0;
    end else begin
      if (cmd.load_sq) begin
        last_r <= in_data.is_last;
      end
      if (cmd.root_start) begin
        acc_r <= '0;
      end else if (cmd.acc_upd) begin
        acc_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sq) begin
      sq_r <= sq_nxt;
    end
    if (cmd.root_start) begin
      sum_r <= sum_nxt;
      rem_r <= sum_nxt;
      res_r <= '0;
      bit_r <= ROOT_BIT0;
      cnt_r <= '0;
    end else if (cmd.root_step) begin
      if (fits) begin
        rem_r <= rem_r - trial[SUM_W-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_r.distance    <= res_r[ROOT_W-1:0];
      out_r.sum_squares <= sum_r;
    end
  end

  assign sts.last_r    = last_r;
  assign sts.root_last = (cnt_r == CNT_LAST);
  assign out_data      = out_r;

endmodule

`default_nettype wire

[src/descriptor_euclidean_distance_top.sv]
// Top level of the descriptor Euclidean distance block.
// Each element transaction occupies the block for a square step, then an accumulate step.
// After the last element the root unit runs 21 iterations, one result bit per cycle.
// The output register frees the block once it is loaded; the load waits while an
// earlier result is still stalled there.
// Synchronous active-low reset clears the accumulator, the state machine and out_valid.
`default_nettype none

module descriptor_euclidean_distance_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ded_pkg::ded_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ded_pkg::ded_out_t     out_data
);
  import ded_pkg::*;

  // The controller owns the handshakes and the sequence of steps; the datapath
  // holds the accumulator, the square-root unit and the result payload.
  ded_cmd_t cmd;
  ded_sts_t sts;

  // In the idle state the controller takes one element transaction and the
  // datapath registers its saturated squared difference. The next cycle adds
  // that square to the accumulator with saturation at the top of the 42-bit
  // range. When the element carried the last mark, the same cycle copies the
  // final sum into the root unit and clears the accumulator for the next vector.
  ded_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The root unit is a restoring digit-by-digit square root that yields one
  // bit of the truncated root per cycle. The result waits in the output
  // register only as long as the downstream side stalls; a new vector may
  // stream in meanwhile, and only the next emit waits for the register to free.
  ded_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[src/ded_checker.sv]
// Port-level checker for the descriptor Euclidean distance block, with its bind.
`default_nettype none

module ded_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire ded_pkg::ded_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire ded_pkg::ded_out_t out_data
);
  import ded_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The distance is the truncated square root of the reported sum.
  a_root_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (64'(out_data.distance) * 64'(out_data.distance) <= 64'(out_data.sum_squares)) &&
      ((64'(out_data.distance) + 64'd1) * (64'(out_data.distance) + 64'd1) >
        64'(out_data.sum_squares)))
    else $error("distance is not the square root of the sum");

  // One element at a time: ready drops right after a transaction.
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second element taken while busy");

  // A result never appears in the cycle after an element is taken.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised too early");

endmodule

bind descriptor_euclidean_distance_top ded_checker u_ded_checker (.*);

`default_nettype wire
